>>> hw/rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared definitions for the 3x3 edge-aware box blur
// Constants, register codes and the structs passed between the blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Default sizes and register reset values.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int FRAME_WIDTH_RST = 1024;
  localparam int FRAME_HEIGHT_RST = 480;

  // Register field widths; the data port is as wide as the widest one.
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 13;
  localparam int CFG_DATA_W = 13;

  // Pixel and arithmetic widths.
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int ENTRY_W  = 2 * PIX_W;
  localparam int SUM_W    = 12;           // nine 8-bit values
  localparam int CNT_W    = 4;            // tap count, 1..9
  localparam int NUM_W    = SUM_W + 1;    // 2*sum + count
  localparam int RECIP_W  = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // Reciprocals scaled by 2^16; exact for every quotient that can occur here.
  localparam logic [RECIP_W-1:0] RECIP_ONE  = 17'd65536;
  localparam logic [RECIP_W-1:0] RECIP_DIV3 = 17'd21846;
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = 17'd7282;

  localparam int OUT_FIFO_DEPTH = 8;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Which neighbors of the output pixel lie inside the frame.
  typedef struct packed {
    logic row_up;
    logic row_dn;
    logic col_lf;
    logic col_rt;
    logic last;
  } pos_t;

  // Per-channel box sums: index 2 is red, 1 green, 0 blue.
  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]      cnt;
  } box_sum_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } result_t;

endpackage

>>> hw/rtl/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core: 3x3 edge-aware box blur on an RGB stream
// Pixels enter in raster order; each leaves as the rounded mean of its 3x3
// neighbors that lie inside the frame (4, 6 or 9 of them in general).
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes one request per pixel in
//   raster order. After the last pixel of a frame the source sends
//   frame_width+1 requests with drain_i set to flush the last row. The output
//   channel (out_valid_o/out_ready_i) carries one blurred pixel per request;
//   frame_last_o marks the frame's final pixel.
//   The result for a pixel is produced by the request frame_width+1 positions
//   later. With an empty queue, its result passes stages B, C, D and E and is
//   written into the result queue, which then raises out_valid_o.
//   One request is accepted every cycle while in_ready_o is high; the line
//   store is read and written once per pixel; its single port pair sets that rate.
//   A receiver stall fills an 8-entry result queue; in_ready_o drops once the
//   queue plus the results still in the pipeline would fill it.
//   Reset clears the position counters, the window and the queue and sets the
//   width to 1024 and the height to 480. The line store needs no clearing:
//   entries not yet written only feed taps outside the frame.
//   A write to either register restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bb3_pkg::CH_W-1:0]       in_red_i,
  input  logic [bb3_pkg::CH_W-1:0]       in_green_i,
  input  logic [bb3_pkg::CH_W-1:0]       in_blue_i,
  input  logic                           drain_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bb3_pkg::CH_W-1:0]       out_red_o,
  output logic [bb3_pkg::CH_W-1:0]       out_green_o,
  output logic [bb3_pkg::CH_W-1:0]       out_blue_o,
  output logic                           frame_last_o
);
  import bb3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int FCW   = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCC_W = FCW + 1;
  localparam int W_LAST_RST =
      (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1 : FRAME_WIDTH_RST - 1;
  localparam int H_LAST_RST =
      (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT - 1 : FRAME_HEIGHT_RST - 1;
  localparam logic [1:0] ROW_TWO = 2'd2;

  // The registers are kept as "size in use minus one", already clamped.
  logic [CW-1:0] w_last_q, w_last_d;
  logic [RW-1:0] h_last_q, h_last_d;
  logic [CW-1:0] w_last_cfg;
  logic [RW-1:0] h_last_cfg;
  logic [31:0]   fw_ext, fh_ext;

  // Position counters. in_row_q only needs to tell rows 0, 1 and beyond.
  logic [CW-1:0] in_col_q, in_col_d;
  logic [1:0]    in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;

  logic          accept;
  logic          emit;
  logic          col_wrap;
  pos_t          pos_a;

  // Pipeline stages: B reads the line store and shifts the window, C sums,
  // D multiplies by the reciprocal, E writes the result queue.
  logic              b_v_q, b_emit_q;
  logic [PIX_W-1:0]  b_pix_q;
  logic [CW-1:0]     b_col_q;
  pos_t              b_pos_q;
  logic              c_v_q;
  pos_t              c_pos_q;
  logic              d_v_q, d_last_q;
  logic              e_v_q, e_last_q;

  logic [ENTRY_W-1:0] rd_entry;
  logic [PIX_W-1:0]   up2, up1;
  box_sum_t           box;
  logic [2:0][CH_W-1:0] mean;
  result_t            push_data;
  result_t            fifo_data;
  logic [FCW-1:0]     fifo_cnt;
  logic [OCC_W-1:0]   occupancy;

  // --------------------------------------------------------------------------
  // Flow control: accept only while the queue has room for every result that
  // may still be in flight, so the pipeline itself never has to stall.
  // --------------------------------------------------------------------------
  always_comb begin
    occupancy = OCC_W'(fifo_cnt) + OCC_W'(b_v_q && b_emit_q) + OCC_W'(c_v_q)
              + OCC_W'(d_v_q) + OCC_W'(e_v_q);
  end

  assign in_ready_o = (occupancy < OCC_W'(OUT_FIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Register writes, clamped to 1..MAX on the way in.
  // --------------------------------------------------------------------------
  always_comb begin
    fw_ext = 32'(cfg_data_i[FW_BITS-1:0]);
    fh_ext = 32'(cfg_data_i[FH_BITS-1:0]);
    if (fw_ext == 32'd0) begin
      w_last_cfg = '0;
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(fw_ext - 32'd1);
    end
    if (fh_ext == 32'd0) begin
      h_last_cfg = '0;
    end else if (fh_ext > 32'(MAX_HEIGHT)) begin
      h_last_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last_cfg = RW'(fh_ext - 32'd1);
    end
  end

  // --------------------------------------------------------------------------
  // Input position and output position. An item produces a result once the
  // stream is a full row plus one pixel past the output position; the output
  // position never leaves the frame because the final pixel clears all
  // counters and starts the next frame.
  // --------------------------------------------------------------------------
  always_comb begin
    emit     = (in_row_q >= ROW_TWO) || (in_row_q == 2'd1 && in_col_q != '0);
    col_wrap = (in_col_q == w_last_q);

    pos_a.row_up = (out_row_q != '0);
    pos_a.row_dn = (out_row_q != h_last_q);
    pos_a.col_lf = (out_col_q != '0);
    pos_a.col_rt = (out_col_q != w_last_q);
    pos_a.last   = !pos_a.row_dn && !pos_a.col_rt;

    w_last_d  = w_last_q;
    h_last_d  = h_last_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  w_last_d = w_last_cfg;
        REG_FRAME_HEIGHT: h_last_d = h_last_cfg;
        default: ;
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      in_col_d = col_wrap ? '0 : in_col_q + CW'(1);
      if (col_wrap && in_row_q != ROW_TWO) begin
        in_row_d = in_row_q + 2'd1;
      end
      if (emit) begin
        if (pos_a.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (!pos_a.col_rt) begin
          out_col_d = '0;
          out_row_d = out_row_q + RW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q  <= CW'(W_LAST_RST);
      h_last_q  <= RW'(H_LAST_RST);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      w_last_q  <= w_last_d;
      h_last_q  <= h_last_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline valid flags and the data that travels with them.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      b_v_q <= accept;
      c_v_q <= b_v_q && b_emit_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pix_q  <= drain_i ? '0 : {in_red_i, in_green_i, in_blue_i};
      b_col_q  <= in_col_q;
      b_emit_q <= emit;
      b_pos_q  <= pos_a;
    end
    if (b_v_q) begin
      c_pos_q <= b_pos_q;
    end
    if (c_v_q) begin
      d_last_q <= c_pos_q.last;
    end
    if (d_v_q) begin
      e_last_q <= d_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: read at accept, write the shifted column back in stage B.
  // Entry layout is {two rows back, one row back}.
  // --------------------------------------------------------------------------
  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_col_q),
    .wr_en_i   (b_v_q),
    .wr_addr_i (b_col_q),
    .wr_data_i ({up1, b_pix_q}),
    .rd_data_o (rd_entry)
  );

  assign up2 = rd_entry[ENTRY_W-1:PIX_W];
  assign up1 = rd_entry[PIX_W-1:0];

  bb3_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (b_v_q),
    .up2_i      (up2),
    .up1_i      (up1),
    .pix_i      (b_pix_q),
    .sum_en_i   (c_v_q),
    .pos_i      (c_pos_q),
    .box_o      (box)
  );

  bb3_div u_div (
    .clk_i  (clk_i),
    .en_i   (d_v_q),
    .box_i  (box),
    .mean_o (mean)
  );

  // --------------------------------------------------------------------------
  // Result queue.
  // --------------------------------------------------------------------------
  always_comb begin
    push_data.red   = mean[2];
    push_data.green = mean[1];
    push_data.blue  = mean[0];
    push_data.last  = e_last_q;
  end

  bb3_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (e_v_q),
    .push_data_i (push_data),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (fifo_data),
    .count_o     (fifo_cnt)
  );

  assign out_red_o    = fifo_data.red;
  assign out_green_o  = fifo_data.green;
  assign out_blue_o   = fifo_data.blue;
  assign frame_last_o = fifo_data.last;

endmodule

>>> hw/rtl/bb3_line_store.sv
// ----------------------------------------------------------------------------
// bb3_line_store: two-row line store
// One synchronous memory holds the two previous rows side by side, with a
// registered read and a bypass for a read that hits the entry being written.
// ----------------------------------------------------------------------------
module bb3_line_store #(
  parameter int  DEPTH = bb3_pkg::MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [bb3_pkg::ENTRY_W-1:0] wr_data_i,
  output logic [bb3_pkg::ENTRY_W-1:0] rd_data_o
);
  import bb3_pkg::*;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] fwd_data_q;
  logic               fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // A read issued in the same cycle as a write to the same entry sees the old
  // contents, so the written data is kept and used instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> hw/rtl/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window: 3x3 window and masked box sum
// Shifts one column into the window per item and sums the taps that lie
// inside the frame, with their count.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_en_i,
  input  logic [bb3_pkg::PIX_W-1:0] up2_i,
  input  logic [bb3_pkg::PIX_W-1:0] up1_i,
  input  logic [bb3_pkg::PIX_W-1:0] pix_i,
  input  logic                      sum_en_i,
  input  bb3_pkg::pos_t             pos_i,
  output bb3_pkg::box_sum_t         box_o
);
  import bb3_pkg::*;

  // window_q[line][tap]: line 0 is the oldest row, tap 2 the newest column.
  logic [PIX_W-1:0] window_q [3][3];
  box_sum_t         box_d;
  box_sum_t         box_q;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 3; l++) begin
        for (int t = 0; t < 3; t++) begin
          window_q[l][t] <= '0;
        end
      end
    end else if (shift_en_i) begin
      for (int l = 0; l < 3; l++) begin
        window_q[l][0] <= window_q[l][1];
        window_q[l][1] <= window_q[l][2];
      end
      window_q[0][2] <= up2_i;
      window_q[1][2] <= up1_i;
      window_q[2][2] <= pix_i;
    end
  end

  always_comb begin
    row_ok = {pos_i.row_dn, 1'b1, pos_i.row_up};
    col_ok = {pos_i.col_rt, 1'b1, pos_i.col_lf};
    rows   = CNT_W'(1) + CNT_W'(pos_i.row_up) + CNT_W'(pos_i.row_dn);
    cols   = CNT_W'(1) + CNT_W'(pos_i.col_lf) + CNT_W'(pos_i.col_rt);
    box_d  = '0;
    for (int l = 0; l < 3; l++) begin
      for (int t = 0; t < 3; t++) begin
        if (row_ok[l] && col_ok[t]) begin
          for (int ch = 0; ch < 3; ch++) begin
            box_d.sum[ch] = box_d.sum[ch] + SUM_W'(window_q[l][t][CH_W*ch +: CH_W]);
          end
        end
      end
    end
    box_d.cnt = rows * cols;
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

>>> hw/rtl/bb3_div.sv
// ----------------------------------------------------------------------------
// bb3_div: rounded mean by constant reciprocal
// Computes floor((2*sum + count) / (2*count)) per channel with a shift and a
// multiply by a scaled reciprocal of 1, 3 or 9.
// ----------------------------------------------------------------------------
module bb3_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  bb3_pkg::box_sum_t            box_i,
  output logic [2:0][bb3_pkg::CH_W-1:0] mean_o
);
  import bb3_pkg::*;

  logic [1:0]              sh;
  logic [RECIP_W-1:0]      recip;
  logic [NUM_W-1:0]        num     [3];
  logic [NUM_W-1:0]        shifted [3];
  logic [PROD_W-1:0]       prod_d  [3];
  logic [PROD_W-1:0]       prod_q  [3];

  // Divisor 2*count splits into a power of two and a factor of 1, 3 or 9.
  always_comb begin
    case (box_i.cnt)
      4'd1:    begin sh = 2'd1; recip = RECIP_ONE;  end
      4'd2:    begin sh = 2'd2; recip = RECIP_ONE;  end
      4'd3:    begin sh = 2'd1; recip = RECIP_DIV3; end
      4'd4:    begin sh = 2'd3; recip = RECIP_ONE;  end
      4'd6:    begin sh = 2'd2; recip = RECIP_DIV3; end
      4'd9:    begin sh = 2'd1; recip = RECIP_DIV9; end
      default: begin sh = 2'd1; recip = RECIP_ONE;  end
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]     = {box_i.sum[ch], 1'b0} + NUM_W'(box_i.cnt);
      shifted[ch] = num[ch] >> sh;
      prod_d[ch]  = PROD_W'(shifted[ch]) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= prod_d[ch];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_o[ch] = prod_q[ch][RECIP_SHIFT +: CH_W];
    end
  end

endmodule

>>> hw/rtl/bb3_out_fifo.sv
// ----------------------------------------------------------------------------
// bb3_out_fifo: result queue
// Small register FIFO that decouples the blur pipeline from the receiver and
// reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module bb3_out_fifo #(
  parameter int  DEPTH = bb3_pkg::OUT_FIFO_DEPTH,
  localparam int PW    = $clog2(DEPTH),
  localparam int FCW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bb3_pkg::result_t  push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output bb3_pkg::result_t  data_o,
  output logic [FCW-1:0]    count_o
);
  import bb3_pkg::*;

  result_t        store_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCW-1:0] count_q, count_d;
  logic           do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = store_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + FCW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - FCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
